/* rtl/luhn_pkg.sv */
package luhn_pkg;

  localparam int unsigned NUMBER_BITS_DEF = 63;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned BRAND_W         = 2;

  localparam logic [BRAND_W-1:0] BRAND_INVALID = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_PAT_3X  = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_PAT_4   = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_PAT_5X  = 2'd3;

  localparam logic [LEN_W-1:0] LEN_MIN_BRAND = 5'd12;
  localparam logic [LEN_W-1:0] LEN_13        = 5'd13;
  localparam logic [LEN_W-1:0] LEN_15        = 5'd15;
  localparam logic [LEN_W-1:0] LEN_16        = 5'd16;

  typedef struct packed {
    logic load;
    logic conv;
    logic shr;
  } luhn_bcd_cmd_t;

  typedef struct packed {
    logic                 sum_zero;
    logic [LEN_W-1:0]     len;
    logic [DIGIT_W-1:0]   lead_hi;
    logic [DIGIT_W-1:0]   lead_lo;
  } luhn_scan_sts_t;

endpackage

/* rtl/luhn_bcd.sv */
module luhn_bcd
  import luhn_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int unsigned DIGITS      = 19
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  luhn_bcd_cmd_t          cmd_i,
  input  logic [NUMBER_BITS-1:0] number_i,
  output logic [DIGIT_W-1:0]     digit_o
);

  localparam int unsigned BCD_W = DIGITS * DIGIT_W;

  logic [NUMBER_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       adj;

  // shift-add-3 correction on every digit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = number_i;
      bcd_d = '0;
    end else if (cmd_i.conv) begin
      bin_d = {bin_q[NUMBER_BITS-2:0], 1'b0};
      bcd_d = {adj[BCD_W-2:0], bin_q[NUMBER_BITS-1]};
    end else if (cmd_i.shr) begin
      bcd_d = {{DIGIT_W{1'b0}}, bcd_q[BCD_W-1:DIGIT_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      bcd_q <= '0;
    end else begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign digit_o = bcd_q[DIGIT_W-1:0];

endmodule

/* rtl/luhn_scan.sv */
module luhn_scan
  import luhn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output luhn_scan_sts_t     sts_o
);

  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [DIGIT_W-1:0] sum_q, sum_d;
  logic [DIGIT_W-1:0] prev_q, prev_d;
  logic [DIGIT_W-1:0] hi_q, hi_d;
  logic [DIGIT_W-1:0] lo_q, lo_d;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W-1:0] contrib;
  logic [DIGIT_W:0]   acc;

  always_comb begin
    dbl = {digit_i, 1'b0};
    if (!pos_q[0]) begin
      contrib = digit_i;
    end else if (dbl > (DIGIT_W+1)'(9)) begin
      contrib = DIGIT_W'(dbl - (DIGIT_W+1)'(9));
    end else begin
      contrib = DIGIT_W'(dbl);
    end
    acc = {1'b0, sum_q} + {1'b0, contrib};
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    sum_d  = sum_q;
    prev_d = prev_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (clr_i) begin
      pos_d  = '0;
      len_d  = '0;
      sum_d  = '0;
      prev_d = '0;
      hi_d   = '0;
      lo_d   = '0;
    end else if (en_i) begin
      pos_d  = pos_q + LEN_W'(1);
      prev_d = digit_i;
      // running sum kept modulo ten
      if (acc >= (DIGIT_W+1)'(10)) begin
        sum_d = DIGIT_W'(acc - (DIGIT_W+1)'(10));
      end else begin
        sum_d = DIGIT_W'(acc);
      end
      if (digit_i != '0) begin
        len_d = pos_q + LEN_W'(1);
        hi_d  = digit_i;
        lo_d  = prev_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      sum_q  <= '0;
      prev_q <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
      prev_q <= prev_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

  assign sts_o.sum_zero = (sum_q == '0);
  assign sts_o.len      = len_q;
  assign sts_o.lead_hi  = hi_q;
  assign sts_o.lead_lo  = lo_q;

endmodule

/* rtl/card_number_luhn_classify_top.sv */
// Sequence from start accept to done_o: one shift-add-3 step per input bit, then one
//   digit per cycle, then a finishing step; DIGITS = floor(0.30103*NUMBER_BITS)+1.
// A new word is accepted only while idle, so words never overlap.
// busy_o is high for the whole run; a new word may be started while done_o is high.
// done_o marks the result for exactly one cycle; the receiver cannot stall it.
module card_number_luhn_classify_top
  import luhn_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [NUMBER_BITS-1:0] number_value_i,
  output logic                   done_o,
  output logic [BRAND_W-1:0]     brand_code_o,
  output logic                   checksum_ok_o,
  output logic [LEN_W-1:0]       digit_count_o
);

  localparam int unsigned DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
  localparam int unsigned CNT_W  = $clog2(NUMBER_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [BRAND_W-1:0] brand_q, brand_d;
  logic               ok_q, ok_d;
  logic [LEN_W-1:0]   len_q, len_d;

  luhn_bcd_cmd_t      bcd_cmd;
  logic [DIGIT_W-1:0] digit;
  luhn_scan_sts_t     sts;
  logic               accept;
  logic               scan_en;
  logic [BRAND_W-1:0] brand;

  assign accept = start_i && (state_q == S_IDLE);

  luhn_bcd #(
    .NUMBER_BITS (NUMBER_BITS),
    .DIGITS      (DIGITS)
  ) u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (bcd_cmd),
    .number_i (number_value_i),
    .digit_o  (digit)
  );

  luhn_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (accept),
    .en_i    (scan_en),
    .digit_i (digit),
    .sts_o   (sts)
  );

  always_comb begin
    brand = BRAND_INVALID;
    if (sts.sum_zero && (sts.len > LEN_MIN_BRAND)) begin
      if (sts.len == LEN_15) begin
        if ((sts.lead_hi == DIGIT_W'(3)) &&
            ((sts.lead_lo == DIGIT_W'(4)) || (sts.lead_lo == DIGIT_W'(7)))) begin
          brand = BRAND_PAT_3X;
        end
      end else if (sts.len == LEN_13) begin
        if (sts.lead_hi == DIGIT_W'(4)) begin
          brand = BRAND_PAT_4;
        end
      end else if (sts.len == LEN_16) begin
        if ((sts.lead_hi == DIGIT_W'(5)) && (sts.lead_lo >= DIGIT_W'(1)) &&
            (sts.lead_lo <= DIGIT_W'(5))) begin
          brand = BRAND_PAT_5X;
        end else if (sts.lead_hi == DIGIT_W'(4)) begin
          brand = BRAND_PAT_4;
        end
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    brand_d      = brand_q;
    ok_d         = ok_q;
    len_d        = len_q;
    bcd_cmd.load = 1'b0;
    bcd_cmd.conv = 1'b0;
    bcd_cmd.shr  = 1'b0;
    scan_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          bcd_cmd.load = 1'b1;
          cnt_d        = '0;
          state_d      = S_CONV;
        end
      end
      S_CONV: begin
        bcd_cmd.conv = 1'b1;
        cnt_d        = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUMBER_BITS - 1)) begin
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        bcd_cmd.shr = 1'b1;
        scan_en     = 1'b1;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        brand_d = brand;
        ok_d    = sts.sum_zero;
        len_d   = sts.len;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    brand_q <= brand_d;
    ok_q    <= ok_d;
    len_q   <= len_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign brand_code_o  = brand_q;
  assign checksum_ok_o = ok_q;
  assign digit_count_o = len_q;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_FIN))
    else $error("done without finishing step");

  a_brand_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (brand_code_o != BRAND_INVALID)) |-> checksum_ok_o)
    else $error("brand reported on failed checksum");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (digit_count_o <= LEN_W'(DIGITS)))
    else $error("digit count out of range");
`endif

endmodule
